// ===== hdl/tpct_pkg.sv =====
// shared types and constants for the tick pwm and countdown timer block
package tpct_pkg;

    // default number of countdown channels
    localparam int NUM_COUNTDOWNS_DEF = 3;
    // compare width for channel numbers, covers up to 31 channels
    localparam int CH_CMP_W = 5;

    // request operation codes
    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_SET_COUNT  = 3'd1,
        OP_READ_COUNT = 3'd2,
        OP_SET_DUTY   = 3'd3,
        OP_START      = 3'd4,
        OP_STOP       = 3'd5,
        OP_INIT_PWM   = 3'd6,
        OP_PAUSE      = 3'd7
    } op_t;

    // one request
    typedef struct packed {
        op_t         operation;
        logic [1:0]  index;
        logic [31:0] value;
    } in_item_t;

    // one result
    typedef struct packed {
        logic        pwm_level;
        logic [31:0] read_value;
        logic        pause_busy;
    } out_item_t;

endpackage

// ===== hdl/tick_pwm_and_countdown_timers_top.sv =====
// top level: tick pwm generator, countdown timers and pause counter
// latency: a result is registered; it drives the output the cycle after acceptance unless an older result waits
// throughput: one request per cycle while the skid entry is empty; state is updated in the accept cycle
// two-entry result queue: one request is taken behind a waiting result, then input stalls
// reset: asynchronous active low; period, duty, counts, timers and pwm state clear to zero
// the queue empties on reset
module tick_pwm_and_countdown_timers_top #(
    parameter int NUM_COUNTDOWNS = tpct_pkg::NUM_COUNTDOWNS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tpct_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tpct_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_data
);

    logic [31:0] period_reg;
    logic [31:0] tick_count_reg, tick_count_next;
    logic [31:0] duty_reg, duty_next;
    logic        pwm_enabled_reg, pwm_enabled_next;
    logic        level_reg, level_next;
    logic [15:0] pause_count_reg, pause_count_next;
    logic [31:0] countdown_reg  [NUM_COUNTDOWNS];
    logic [31:0] countdown_next [NUM_COUNTDOWNS];

    tpct_pkg::out_item_t head_reg, skid_reg, result;
    logic                head_valid_reg, skid_valid_reg;

    logic        in_fire, out_fire;
    logic        ch_valid;
    logic [31:0] read_sel;
    logic [32:0] tick_inc;
    logic        tick_at_period, tick_ge_duty;

    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;
    assign cfg_ready = 1'b1;

    // channel number check and read mux
    assign ch_valid = tpct_pkg::CH_CMP_W'(in_data.index)
                      < tpct_pkg::CH_CMP_W'(NUM_COUNTDOWNS);
    always_comb
    begin
        read_sel = 32'd1;
        for (int k = 0; k < NUM_COUNTDOWNS; k++)
        begin
            if (tpct_pkg::CH_CMP_W'(in_data.index) == tpct_pkg::CH_CMP_W'(k))
            begin
                read_sel = countdown_reg[k];
            end
        end
    end

    // tick count compares, done in parallel with the increment
    assign tick_inc = {1'b0, tick_count_reg} + 33'd1;
    always_comb
    begin
        if (tick_count_reg >= period_reg)
        begin
            tick_at_period = 1'b1;
            tick_ge_duty   = (period_reg >= duty_reg);
        end
        else
        begin
            tick_at_period = (tick_inc == {1'b0, period_reg});
            tick_ge_duty   = (tick_inc >= {1'b0, duty_reg});
        end
    end

    // next state and result for the current request
    always_comb
    begin
        tick_count_next  = tick_count_reg;
        duty_next        = duty_reg;
        pwm_enabled_next = pwm_enabled_reg;
        level_next       = level_reg;
        pause_count_next = pause_count_reg;
        for (int k = 0; k < NUM_COUNTDOWNS; k++)
        begin
            countdown_next[k] = countdown_reg[k];
        end
        result.read_value = 32'd0;

        unique case (in_data.operation)
            tpct_pkg::OP_TICK:
            begin
                if (pwm_enabled_reg)
                begin
                    if (tick_at_period && (duty_reg != 32'd0))
                    begin
                        level_next      = 1'b1;
                        tick_count_next = 32'd0;
                    end
                    else
                    begin
                        tick_count_next = tick_at_period ? period_reg : tick_inc[31:0];
                        if (tick_ge_duty)
                        begin
                            level_next = 1'b0;
                        end
                    end
                end
                for (int k = 0; k < NUM_COUNTDOWNS; k++)
                begin
                    if (countdown_reg[k] != 32'd0)
                    begin
                        countdown_next[k] = countdown_reg[k] - 32'd1;
                    end
                end
                if (pause_count_reg != 16'd0)
                begin
                    pause_count_next = pause_count_reg - 16'd1;
                end
            end
            tpct_pkg::OP_SET_COUNT:
            begin
                for (int k = 0; k < NUM_COUNTDOWNS; k++)
                begin
                    if (tpct_pkg::CH_CMP_W'(in_data.index) == tpct_pkg::CH_CMP_W'(k))
                    begin
                        countdown_next[k] = in_data.value;
                    end
                end
            end
            tpct_pkg::OP_READ_COUNT:
            begin
                result.read_value = ch_valid ? read_sel : 32'd1;
            end
            tpct_pkg::OP_SET_DUTY:
            begin
                duty_next = (in_data.value < period_reg) ? in_data.value : period_reg;
            end
            tpct_pkg::OP_START:
            begin
                pwm_enabled_next = 1'b1;
            end
            tpct_pkg::OP_STOP:
            begin
                pwm_enabled_next = 1'b0;
            end
            tpct_pkg::OP_INIT_PWM:
            begin
                duty_next        = in_data.value;
                tick_count_next  = 32'd0;
                pwm_enabled_next = 1'b1;
            end
            tpct_pkg::OP_PAUSE:
            begin
                pause_count_next = in_data.value[15:0];
            end
        endcase

        result.pwm_level  = level_next;
        result.pause_busy = (pause_count_next != 16'd0);
    end

    // timer state, updated on each accepted request; the period loads from the config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg      <= 32'd0;
            tick_count_reg  <= 32'd0;
            duty_reg        <= 32'd0;
            pwm_enabled_reg <= 1'b0;
            level_reg       <= 1'b0;
            pause_count_reg <= 16'd0;
            for (int k = 0; k < NUM_COUNTDOWNS; k++)
            begin
                countdown_reg[k] <= 32'd0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                period_reg <= cfg_data;
            end
            if (in_fire)
            begin
                tick_count_reg  <= tick_count_next;
                duty_reg        <= duty_next;
                pwm_enabled_reg <= pwm_enabled_next;
                level_reg       <= level_next;
                pause_count_reg <= pause_count_next;
                for (int k = 0; k < NUM_COUNTDOWNS; k++)
                begin
                    countdown_reg[k] <= countdown_next[k];
                end
            end
        end
    end

    // two-entry result queue: head drives the port, skid catches a stalled result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (!head_valid_reg || out_fire)
            begin
                head_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            head_valid_reg <= 1'b0;
        end
    end

    // result payload moves
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                head_reg <= skid_reg;
            end
        end
        else if (in_fire)
        begin
            if (!head_valid_reg || out_fire)
            begin
                head_reg <= result;
            end
            else
            begin
                skid_reg <= result;
            end
        end
    end

`ifndef SYNTHESIS
    // skid entry is only ever filled behind a full head
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
    else $error("skid holds a result while head is empty");

    // output valid is high the cycle after every accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid)
    else $error("accepted request produced no result");

    // tick count is frozen while the pwm is disabled
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_data.operation == tpct_pkg::OP_TICK) && !pwm_enabled_reg)
        |=> $stable(tick_count_reg))
    else $error("tick count moved while pwm disabled");

    // a read of a missing channel returns one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !skid_valid_reg && (!head_valid_reg || out_fire)
         && (in_data.operation == tpct_pkg::OP_READ_COUNT) && !ch_valid)
        |=> (out_data.read_value == 32'd1))
    else $error("invalid channel read did not return one");
`endif

endmodule

// ===== verif/tick_pwm_and_countdown_timers_top_tb.sv =====
// self-checking testbench for the tick pwm and countdown timer block, predictor-based
module tick_pwm_and_countdown_timers_top_tb;
    import tpct_pkg::*;

    localparam int NUM_CD       = NUM_COUNTDOWNS_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 290;
    localparam int NUM_PHASES   = 6;
    localparam int HOLD_CYCLES  = 60;
    localparam int NUM_DIRECTED = 25;

    // one row of the directed table; result is only used where known is set
    typedef struct {
        op_t         op;
        logic [1:0]  index;
        logic [31:0] value;
        bit          known;
        out_item_t   result;
    } dir_row_t;

    // hand-written result that travels along with each request
    typedef struct {
        bit        known;
        out_item_t result;
    } hand_check_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    // predictor copy of the block state
    logic [31:0] prd_period;
    logic [31:0] prd_ticks;
    logic [31:0] prd_duty;
    bit          prd_enabled;
    bit          prd_level;
    logic [31:0] prd_countdown [NUM_CD];
    logic [15:0] prd_pause;

    out_item_t   expected_results [$];
    hand_check_t hand_results [$];

    int unsigned cur_period    = 0;
    int          send_idle_pct = 29;
    int          recv_idle_pct = 48;
    bit          hold_req      = 1'b0;
    int          hold_left     = 0;
    int          sent_count    = 0;
    int          errors        = 0;
    int          cycle_count   = 0;

    // directed requests, run with the period still at its reset value
    dir_row_t directed_rows [NUM_DIRECTED] = '{
        '{OP_READ_COUNT, 2'd0, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
        '{OP_READ_COUNT, 2'd3, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0001, 1'b0}},
        '{OP_SET_COUNT,  2'd3, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
        '{OP_READ_COUNT, 2'd3, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0000_0001, 1'b0}},
        '{OP_SET_COUNT,  2'd0, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
        '{OP_READ_COUNT, 2'd0, 32'h0000_0000, 1'b1, '{1'b0, 32'hFFFF_FFFF, 1'b0}},
        '{OP_SET_COUNT,  2'd1, 32'h0000_0001, 1'b0, '{1'b0, 32'h0000_0000, 1'b0}},
        '{OP_SET_COUNT,  2'd2, 32'h0000_0000, 1'b0, '{1'b0, 32'h0000_0000, 1'b0}},
        '{OP_TICK,       2'd3, 32'hFFFF_FFFF, 1'b0, '{1'b0, 32'h0000_0000, 1'b0}},
        '{OP_READ_COUNT, 2'd0, 32'h0000_0000, 1'b0, '{1'b0, 32'h0000_0000, 1'b0}},
        '{OP_READ_COUNT, 2'd1, 32'h0000_0000, 1'b0, '{1'b0, 32'h0000_0000, 1'b0}},
        '{OP_PAUSE,      2'd0, 32'hFFFF_0000, 1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
        '{OP_PAUSE,      2'd1, 32'h0001_0002, 1'b1, '{1'b0, 32'h0000_0000, 1'b1}},
        '{OP_TICK,       2'd0, 32'h0000_0000, 1'b0, '{1'b0, 32'h0000_0000, 1'b0}},
        '{OP_TICK,       2'd2, 32'h5555_AAAA, 1'b0, '{1'b0, 32'h0000_0000, 1'b0}},
        '{OP_SET_DUTY,   2'd0, 32'hFFFF_FFFF, 1'b0, '{1'b0, 32'h0000_0000, 1'b0}},
        '{OP_START,      2'd1, 32'h0000_0000, 1'b0, '{1'b0, 32'h0000_0000, 1'b0}},
        '{OP_TICK,       2'd0, 32'h0000_0000, 1'b0, '{1'b0, 32'h0000_0000, 1'b0}},
        '{OP_INIT_PWM,   2'd2, 32'h0000_0003, 1'b0, '{1'b0, 32'h0000_0000, 1'b0}},
        '{OP_TICK,       2'd0, 32'h0000_0000, 1'b0, '{1'b0, 32'h0000_0000, 1'b0}},
        '{OP_STOP,       2'd3, 32'hFFFF_FFFF, 1'b0, '{1'b0, 32'h0000_0000, 1'b0}},
        '{OP_TICK,       2'd0, 32'h0000_0000, 1'b0, '{1'b0, 32'h0000_0000, 1'b0}},
        '{OP_INIT_PWM,   2'd0, 32'h0000_0000, 1'b0, '{1'b0, 32'h0000_0000, 1'b0}},
        '{OP_TICK,       2'd1, 32'hAAAA_5555, 1'b0, '{1'b0, 32'h0000_0000, 1'b0}},
        '{OP_READ_COUNT, 2'd2, 32'h0000_0000, 1'b0, '{1'b0, 32'h0000_0000, 1'b0}}
    };

    tick_pwm_and_countdown_timers_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    always #5 clk = ~clk;

    // predictor reset state
    initial
    begin
        prd_period  = '0;
        prd_ticks   = '0;
        prd_duty    = '0;
        prd_enabled = 1'b0;
        prd_level   = 1'b0;
        prd_pause   = '0;
        foreach (prd_countdown[k])
            prd_countdown[k] = '0;
    end

    // advance the predicted state by one request and return its result
    function automatic out_item_t pwm_timer_step(in_item_t req);
        out_item_t res;
        logic [31:0] rd;
        rd = '0;
        case (req.operation)
            OP_TICK:
            begin
                if (prd_enabled)
                begin
                    // count saturates at the period
                    if (prd_ticks >= prd_period)
                        prd_ticks = prd_period;
                    else
                        prd_ticks = prd_ticks + 32'd1;
                    if (prd_ticks >= prd_period && prd_duty != '0)
                    begin
                        prd_level = 1'b1;
                        prd_ticks = '0;
                    end
                    else if (prd_ticks >= prd_duty)
                        prd_level = 1'b0;
                end
                foreach (prd_countdown[k])
                    if (prd_countdown[k] != '0)
                        prd_countdown[k] = prd_countdown[k] - 32'd1;
                if (prd_pause != '0)
                    prd_pause = prd_pause - 16'd1;
            end
            OP_SET_COUNT:
                if (req.index < NUM_CD)
                    prd_countdown[req.index] = req.value;
            OP_READ_COUNT:
                rd = (req.index < NUM_CD) ? prd_countdown[req.index] : 32'd1;
            OP_SET_DUTY:
                prd_duty = (req.value < prd_period) ? req.value : prd_period;
            OP_START:
                prd_enabled = 1'b1;
            OP_STOP:
                prd_enabled = 1'b0;
            OP_INIT_PWM:
            begin
                prd_duty    = req.value;
                prd_ticks   = '0;
                prd_enabled = 1'b1;
            end
            default:
                prd_pause = req.value[15:0];
        endcase
        res.pwm_level  = prd_level;
        res.read_value = rd;
        res.pause_busy = (prd_pause != '0);
        return res;
    endfunction

    // compare one result against the oldest expectation
    task automatic check_result(out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0)
        begin
            $error("result with no request pending: %p", got);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        if (got.pwm_level !== want.pwm_level)
        begin
            $error("pwm_level expected %0d actual %0d", want.pwm_level, got.pwm_level);
            errors++;
        end
        if (got.read_value !== want.read_value)
        begin
            $error("read_value expected %h actual %h", want.read_value, got.read_value);
            errors++;
        end
        if (got.pause_busy !== want.pause_busy)
        begin
            $error("pause_busy expected %0d actual %0d", want.pause_busy, got.pause_busy);
            errors++;
        end
    endtask

    // monitor: results first, then config, then new requests
    always @(posedge clk)
    begin
        hand_check_t hand;
        out_item_t   pred;
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_result(out_data);
            if (cfg_valid && cfg_ready)
                prd_period = cfg_data;
            if (in_valid && in_ready)
            begin
                pred = pwm_timer_step(in_data);
                hand = hand_results.pop_front();
                expected_results.push_back(hand.known ? hand.result : pred);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off when asked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // offer one request, idling first at random, and wait for it to be taken
    task automatic send_request(in_item_t req, bit known, out_item_t result);
        hand_check_t hand;
        hand.known  = known;
        hand.result = result;
        hand_results.push_back(hand);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        sent_count++;
    endtask

    task automatic send_op(op_t op, logic [1:0] index, logic [31:0] value);
        in_item_t req;
        req.operation = op;
        req.index     = index;
        req.value     = value;
        send_request(req, 1'b0, '0);
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0 || hand_results.size() != 0);
    endtask

    task automatic write_period(logic [31:0] period);
        cfg_valid <= 1'b1;
        cfg_data  <= period;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_period = period;
    endtask

    // duty values around the current period, sometimes past it
    function automatic logic [31:0] pick_duty();
        if (cur_period <= 64)
            return $urandom_range(0, cur_period + 1);
        return $urandom_range(0, 1) ? $urandom : $urandom_range(0, 64);
    endfunction

    function automatic logic [1:0] pick_channel();
        return ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    endfunction

    // random requests: mostly pwm runs and countdown sequences, some noise
    task automatic run_random(int target);
        int         scen;
        int         n;
        logic [1:0] ch;
        while (sent_count < target)
        begin
            scen = $urandom_range(0, 99);
            if (scen < 40)
            begin
                // pwm run: init, then ticks with the odd duty or enable change
                send_op(OP_INIT_PWM, 2'($urandom), pick_duty());
                n = (cur_period <= 12) ? $urandom_range(1, 3 * cur_period + 3)
                                       : $urandom_range(1, 30);
                for (int k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_op(op_t'($urandom_range(OP_SET_DUTY, OP_STOP)),
                                2'($urandom), pick_duty());
                    else
                        send_op(OP_TICK, 2'($urandom), $urandom);
                end
            end
            else if (scen < 70)
            begin
                // countdown: load, let it run, read back
                ch = pick_channel();
                send_op(OP_SET_COUNT, ch,
                        ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 30));
                n = $urandom_range(0, 12);
                for (int k = 0; k < n; k++)
                    send_op(OP_TICK, 2'($urandom), $urandom);
                send_op(OP_READ_COUNT, ch, $urandom);
            end
            else if (scen < 80)
            begin
                // pause: short count in the low half, random upper half
                send_op(OP_PAUSE, 2'($urandom),
                        {16'($urandom), ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                    : 16'($urandom_range(0, 8))});
                n = $urandom_range(0, 10);
                for (int k = 0; k < n; k++)
                    send_op(OP_TICK, 2'($urandom), $urandom);
            end
            else
            begin
                // noise
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++)
                    send_op(op_t'($urandom_range(0, 7)), 2'($urandom), $urandom);
            end
        end
    endtask

    // stimulus
    initial
    begin
        in_item_t    req;
        out_item_t   result;
        logic [31:0] periods [NUM_PHASES];
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (directed_rows[i])
        begin
            req.operation = directed_rows[i].op;
            req.index     = directed_rows[i].index;
            req.value     = directed_rows[i].value;
            result        = directed_rows[i].result;
            send_request(req, directed_rows[i].known, result);
        end

        // random phases, each under its own period
        periods[0] = 32'd1;
        periods[1] = 32'hFFFF_FFFF;
        periods[2] = $urandom_range(2, 16);
        periods[3] = 32'd0;
        periods[4] = $urandom_range(3, 30);
        periods[5] = $urandom;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            case (ph / 2)
                0:
                begin
                    send_idle_pct = 29;
                    recv_idle_pct = 48;
                end
                1:
                begin
                    send_idle_pct = 48;
                    recv_idle_pct = 29;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_period(periods[ph]);
            // long receiver hold-off while requests keep coming
            if (ph == 4)
                hold_req = 1'b1;
            run_random(sent_count + PHASE_ITEMS);
        end

        drain();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
